>>> rtl/integer_to_ascii_converter_unit_defines.svh
// Assertion macros for the integer to ASCII converter.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef INTEGER_TO_ASCII_CONVERTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_CONVERTER_UNIT_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define I2A_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define I2A_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/i2a_pkg.sv
// Shared types, codes and constants of the integer to ASCII converter.
// No dependencies.
package i2a_pkg;

    localparam int VALUE_W = 64;
    localparam int BCD_W   = 80;
    localparam int NIBBLES = BCD_W / 4;
    localparam int CHAR_W  = 7;
    localparam int DIG_W   = 5;
    localparam int ITER_W  = 6;

    localparam logic [DIG_W-1:0]  NUM_DEC_DIGITS = 5'd20;
    localparam logic [DIG_W-1:0]  NUM_HEX_DIGITS = 5'd16;
    localparam logic [ITER_W-1:0] ITER_LAST      = 6'd63;

    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;
    localparam logic [1:0] OP_PTR  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

    localparam logic [CHAR_W-1:0] GLYPHS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_PFX_ZERO,
        ST_PFX_X,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic step;
        logic shift_digit;
    } t_dp_ctrl;

endpackage

>>> rtl/i2a_intf.sv
// Handshake channels of the integer to ASCII converter.
// No dependencies.
interface i2a_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  opcode;

    modport source (output valid, output value, output opcode, input ready);
    modport sink (input valid, input value, input opcode, output ready);
endinterface

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink (input valid, input character, input last, output ready);
endinterface

>>> rtl/i2a_datapath.sv
// Digit register with the shared shift and add-3 unit.
// Depends on i2a_pkg.
module i2a_datapath (
    input  logic                           i_clk,
    input  i2a_pkg::t_dp_ctrl              i_ctrl,
    input  logic [i2a_pkg::VALUE_W-1:0]    i_mag,
    output logic [3:0]                     o_top_digit
);
    import i2a_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [BCD_W-1:0]   w_adj;

    always_comb begin
        for (int i = 0; i < NIBBLES; i++) begin
            w_adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ?
                              (r_bcd[i*4 +: 4] + 4'd3) : r_bcd[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_dec) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (i_ctrl.load_hex) begin
            r_bcd <= {i_mag, {(BCD_W-VALUE_W){1'b0}}};
        end else if (i_ctrl.step) begin
            r_bcd <= {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            r_bin <= {r_bin[VALUE_W-2:0], 1'b0};
        end else if (i_ctrl.shift_digit) begin
            r_bcd <= {r_bcd[BCD_W-5:0], 4'b0000};
        end
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];

endmodule

>>> rtl/integer_to_ascii_converter_unit.sv
// Integer to ASCII converter: sequencer, output register, datapath instance.
// Depends on i2a_pkg, i2a_intf, i2a_datapath and the assertion macros.
// Leading zeros are dropped (up to 19 decimal, 15 hex) before the first character; then
// one character per cycle while the output is not stalled.
// A new number is accepted only once the last character of the previous one is registered.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`include "integer_to_ascii_converter_unit_defines.svh"

module integer_to_ascii_converter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2a_in_if.sink    i_in,
    i2a_out_if.source o_out
);
    import i2a_pkg::*;

    t_state              r_state, n_state;
    logic [ITER_W-1:0]   r_iter, n_iter;
    logic [DIG_W-1:0]    r_dig, n_dig;
    logic                r_pfx, r_neg;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    logic                w_accept;
    logic                w_hex;
    logic                w_neg;
    logic                w_load_out;
    logic                w_skip;
    logic [VALUE_W-1:0]  w_mag;
    logic [3:0]          w_top;
    t_dp_ctrl            s_ctrl;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_hex      = (i_in.opcode == OP_HEX) || (i_in.opcode == OP_PTR);
    assign w_neg      = (i_in.opcode == OP_SDEC) && i_in.value[VALUE_W-1];
    assign w_mag      = w_neg ? (~i_in.value + {{(VALUE_W-1){1'b0}}, 1'b1}) : i_in.value;
    assign w_load_out = !r_out_valid || o_out.ready;
    assign w_skip     = (w_top == 4'd0) && (r_dig > 5'd1);

    i2a_datapath u_datapath (
        .i_clk       (i_clk),
        .i_ctrl      (s_ctrl),
        .i_mag       (w_mag),
        .o_top_digit (w_top)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_hex ? ST_SKIP : ST_CONV;
                end
            end
            ST_CONV: begin
                if (r_iter == ITER_LAST) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (!w_skip) begin
                    if (r_pfx) begin
                        n_state = ST_PFX_ZERO;
                    end else if (r_neg) begin
                        n_state = ST_SIGN;
                    end else begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_PFX_ZERO: begin
                if (w_load_out) begin
                    n_state = ST_PFX_X;
                end
            end
            ST_PFX_X, ST_SIGN: begin
                if (w_load_out) begin
                    n_state = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (w_load_out && (r_dig == 5'd1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ctrl      = '0;
        n_iter      = r_iter;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        case (r_state)
            ST_IDLE: begin
                s_ctrl.load_dec = w_accept && !w_hex;
                s_ctrl.load_hex = w_accept && w_hex;
                n_iter          = '0;
                n_dig           = w_hex ? NUM_HEX_DIGITS : NUM_DEC_DIGITS;
            end
            ST_CONV: begin
                s_ctrl.step = 1'b1;
                n_iter      = r_iter + 6'd1;
            end
            ST_SKIP: begin
                if (w_skip) begin
                    s_ctrl.shift_digit = 1'b1;
                    n_dig              = r_dig - 5'd1;
                end
            end
            ST_PFX_ZERO: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_ZERO;
                    n_last      = 1'b0;
                end
            end
            ST_PFX_X: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_X;
                    n_last      = 1'b0;
                end
            end
            ST_SIGN: begin
                if (w_load_out) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                end
            end
            ST_DIGIT: begin
                if (w_load_out) begin
                    n_out_valid        = 1'b1;
                    n_char             = GLYPHS[w_top];
                    n_last             = (r_dig == 5'd1);
                    s_ctrl.shift_digit = 1'b1;
                    n_dig              = r_dig - 5'd1;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_dig       <= n_dig;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
        if (w_accept) begin
            r_pfx <= (i_in.opcode == OP_PTR);
            r_neg <= w_neg;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    `I2A_ASSERT(a_dig_range, r_dig <= NUM_DEC_DIGITS, "digit count out of range")
    `I2A_ASSERT(a_digit_nonzero, (r_state != ST_DIGIT) || (r_dig != 5'd0), "digit count empty")
    `I2A_ASSERT(a_conv_full, (r_state != ST_CONV) || (r_dig == NUM_DEC_DIGITS), "bad conv count")
    `I2A_ASSERT_NEXT(a_accept_next, w_accept, (r_state == ST_CONV) || (r_state == ST_SKIP), "bad start")

endmodule

>>> dv/integer_to_ascii_converter_unit_tb.sv
// Self-checking testbench for the integer to ASCII converter: drives numbers
// in all four print modes and compares every emitted character with a predictor.
// Depends on i2a_pkg, i2a_intf and the converter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_converter_unit_tb;
    import i2a_pkg::*;

    localparam int RANDOM_NUMBERS = 250;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int HOLD_CYCLES    = 500;

    class ascii_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] character;
            logic              last;
        } t_char;

        t_char pending[$];
        int    failures;

        function new();
            failures = 0;
        endfunction

        function void note_number(logic [VALUE_W-1:0] value, logic [1:0] opcode);
            string             glyphs = "0123456789abcdef";
            logic [VALUE_W-1:0] mag;
            logic [VALUE_W-1:0] radix;
            bit                negative;
            logic [CHAR_W-1:0] digits[$];
            logic [CHAR_W-1:0] text[$];
            t_char             item;
            mag      = value;
            radix    = (opcode == OP_HEX || opcode == OP_PTR) ? 64'd16 : 64'd10;
            negative = (opcode == OP_SDEC) && value[VALUE_W-1];
            if (negative) begin
                mag = ~value + 64'd1;
            end
            do begin
                digits.push_front(CHAR_W'(glyphs[int'(mag % radix)]));
                mag = mag / radix;
            end while (mag != 0 && digits.size() < 20);
            if (opcode == OP_PTR) begin
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
            end
            if (negative) begin
                text.push_back(CH_MINUS);
            end
            foreach (digits[k]) text.push_back(digits[k]);
            foreach (text[k]) begin
                item.character = text[k];
                item.last      = (k == text.size() - 1);
                pending.push_back(item);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] character, logic last);
            t_char want;
            if (pending.size() == 0) begin
                $error("character: none expected, actual %h", character);
                failures++;
                return;
            end
            want = pending.pop_front();
            if (character !== want.character) begin
                $error("character: expected %h, actual %h", want.character, character);
                failures++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, last);
                failures++;
            end
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    i2a_in_if  in_if ();
    i2a_out_if out_if ();

    ascii_scoreboard board = new();

    integer_to_ascii_converter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic offer_number(input logic [VALUE_W-1:0] value, input logic [1:0] opcode,
                                input bit allow_gap);
        if (allow_gap && $urandom_range(99) < 9) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.value  <= value;
        in_if.opcode <= opcode;
        do @(posedge i_clk); while (!in_if.ready);
        board.note_number(value, opcode);
    endtask

    initial begin : stimulus
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] ten_power;
        int                 width;
        in_if.valid  <= 1'b0;
        in_if.value  <= '0;
        in_if.opcode <= OP_SDEC;
        i_rst_n      <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_number(64'd0, OP_SDEC, 1'b1);
        offer_number(64'd0, OP_UDEC, 1'b1);
        offer_number(64'd0, OP_HEX, 1'b1);
        offer_number(64'd0, OP_PTR, 1'b1);
        offer_number(64'd1, OP_SDEC, 1'b1);
        offer_number('1, OP_SDEC, 1'b1);
        offer_number('1, OP_UDEC, 1'b1);
        offer_number('1, OP_HEX, 1'b1);
        offer_number('1, OP_PTR, 1'b1);
        offer_number(64'h8000_0000_0000_0000, OP_SDEC, 1'b1);
        offer_number(64'h8000_0000_0000_0000, OP_UDEC, 1'b1);
        offer_number(64'h8000_0000_0000_0000, OP_HEX, 1'b1);
        offer_number(64'h8000_0000_0000_0000, OP_PTR, 1'b1);
        offer_number(64'h7fff_ffff_ffff_ffff, OP_SDEC, 1'b1);
        offer_number(64'h8ac7_2304_89e7_ffff, OP_UDEC, 1'b1);
        offer_number(64'h8ac7_2304_89e8_0000, OP_UDEC, 1'b1);
        offer_number(64'd9, OP_UDEC, 1'b1);
        offer_number(64'd10, OP_SDEC, 1'b1);
        offer_number(64'd15, OP_HEX, 1'b1);
        offer_number(64'd16, OP_PTR, 1'b1);
        offer_number(64'h0123_4567_89ab_cdef, OP_HEX, 1'b1);
        offer_number(64'hfedc_ba98_7654_3210, OP_PTR, 1'b1);

        for (int n = 0; n < RANDOM_NUMBERS; n++) begin
            case ($urandom_range(3))
                0: value = {$urandom, $urandom};
                1: begin
                    width = $urandom_range(1, VALUE_W);
                    value = {$urandom, $urandom} & ({VALUE_W{1'b1}} >> (VALUE_W - width));
                end
                2: begin
                    value = 64'($urandom_range(999));
                    if ($urandom_range(1)) value = ~value + 64'd1;
                end
                default: begin
                    ten_power = 64'd1;
                    repeat ($urandom_range(19)) ten_power = ten_power * 64'd10;
                    value = ten_power + 64'($urandom_range(2)) - 64'd1;
                    if ($urandom_range(3) == 0) begin
                        value = 64'h8000_0000_0000_0000 + 64'($urandom_range(2));
                    end
                end
            endcase
            offer_number(value, 2'($urandom_range(3)), !(n >= 80 && n < 140));
        end
        in_if.valid <= 1'b0;

        while (!board.drained()) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : drain
        int received;
        int hold;
        bit held;
        received = 0;
        hold     = 0;
        held     = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) begin
                board.check_char(out_if.character, out_if.last);
                received++;
            end
            if (!held && received >= 150) begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                out_if.ready <= 1'b0;
            end else if (received >= 600 && received < 1000) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("simulation failed");
        $finish;
    end

endmodule

>>> integer_to_ascii_converter_unit.f
+incdir+rtl
rtl/i2a_pkg.sv
rtl/i2a_intf.sv
rtl/i2a_datapath.sv
rtl/integer_to_ascii_converter_unit.sv
dv/integer_to_ascii_converter_unit_tb.sv
